### hw/rtl/cwlt_pkg.sv
// constants, command and status types for the word list tokenizer
// shared by cwlt_ctrl, cwlt_datapath and csv_word_list_tokenizer
`default_nettype none
package cwlt_pkg;

  localparam int MAX_WORDS  = 10;
  localparam int WORD_BYTES = 32;
  localparam int BUF_DEPTH  = WORD_BYTES + 1;
  localparam int LEN_W      = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W      = $clog2(MAX_WORDS + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] UTF8_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT = 8'h80;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic store;       // write the input byte into the open word
    logic clear_word;  // drop open word state
    logic close;       // load emit length from trimmed length
    logic rd_from_len; // buffer read address is len, else idx
    logic bk_dec;      // back off one byte
    logic idx_clr;
    logic idx_inc;
    logic ld_word;     // load a word byte beat
    logic ld_end;      // load a list end beat
    logic ld_last;     // last beat of this input byte
    logic count_inc;
    logic count_clr;
  } cmd_t;

  typedef struct packed {
    logic is_nul;
    logic is_comma;
    logic is_blank;
    logic in_word;
    logic full;
    logic trim_gt;
    logic trim_zero;
    logic len_zero;
    logic cont;
    logic last_idx;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/csv_word_list_tokenizer.sv
// comma separated word list tokenizer, one byte per input beat
// a byte that closes no word is taken in S_IDLE; a closing comma or nul then
// visits S_BK_RD and S_BK_CK per utf-8 boundary test of a cut word (one test
// more than the bytes backed off), S_RD and S_OUT per emitted word byte and
// S_END for a nul's list end; the output register lets the next byte in while a
// beat waits; reset clears control state; the word buffer is not cleared
`default_nettype none
module csv_word_list_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      word_byte,
  output logic [3:0]      word_index,
  output logic            word_end,
  output logic [3:0]      word_total,
  output logic            last_of_run
);

  cwlt_pkg::cmd_t cmd;
  cwlt_pkg::sts_t sts;

  cwlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cwlt_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .word_byte   (word_byte),
    .word_index  (word_index),
    .word_end    (word_end),
    .word_total  (word_total),
    .last_of_run (last_of_run)
  );

  // list end beat carries only the count
  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last_of_run && word_byte == 8'h00 && !word_end)
    else $error("list end beat carries word data");

  // word beats carry no total
  a_word_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> word_total == 4'h0)
    else $error("word beat carries a total");

  // a run ends inside a word only on its final byte
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind && last_of_run |-> word_end)
    else $error("run ends before word end");

  // no byte taken in while a word is being emitted
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_word |-> !in_ready)
    else $error("input taken during emit");

endmodule
`default_nettype wire

### hw/rtl/cwlt_datapath.sv
// word buffer, lengths, counters and output register of the tokenizer
// driven by cwlt_ctrl through cwlt_pkg::cmd_t, reports cwlt_pkg::sts_t
`default_nettype none
module cwlt_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          in_byte,
  input  wire cwlt_pkg::cmd_t      cmd,
  output cwlt_pkg::sts_t           sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     kind,
  output logic [7:0]               word_byte,
  output logic [3:0]               word_index,
  output logic                     word_end,
  output logic [3:0]               word_total,
  output logic                     last_of_run
);

  logic [7:0]                 mem [cwlt_pkg::BUF_DEPTH];
  logic [7:0]                 rd_data;
  logic                       in_word;
  logic [cwlt_pkg::LEN_W-1:0] raw_len;
  logic [cwlt_pkg::LEN_W-1:0] trim_len;
  logic [cwlt_pkg::LEN_W-1:0] len;
  logic [cwlt_pkg::LEN_W-1:0] idx;
  logic [cwlt_pkg::CNT_W-1:0] count;

  logic [cwlt_pkg::LEN_W-1:0]  raw_eff;
  logic [cwlt_pkg::LEN_W-1:0]  trim_eff;
  logic [cwlt_pkg::LEN_W-1:0]  raw_next;
  logic                        room;
  logic [cwlt_pkg::LEN_W-1:0]  rd_sel;
  logic [cwlt_pkg::ADDR_W-1:0] rd_addr;

  always_comb begin
    raw_eff  = in_word ? raw_len : '0;
    trim_eff = in_word ? trim_len : '0;
    room     = raw_eff < cwlt_pkg::LEN_W'(cwlt_pkg::BUF_DEPTH);
    raw_next = room ? raw_eff + cwlt_pkg::LEN_W'(1) : raw_eff;
    rd_sel   = cmd.rd_from_len ? len : idx;
    rd_addr  = rd_sel[cwlt_pkg::ADDR_W-1:0];
  end

  always_comb begin
    sts.is_nul    = in_byte == cwlt_pkg::CH_NUL;
    sts.is_comma  = in_byte == cwlt_pkg::CH_COMMA;
    sts.is_blank  = (in_byte == cwlt_pkg::CH_SPACE) || (in_byte == cwlt_pkg::CH_TAB);
    sts.in_word   = in_word;
    sts.full      = count >= cwlt_pkg::CNT_W'(cwlt_pkg::MAX_WORDS);
    sts.trim_gt   = trim_len > cwlt_pkg::LEN_W'(cwlt_pkg::WORD_BYTES);
    sts.trim_zero = trim_len == '0;
    sts.len_zero  = len == '0;
    sts.cont      = (rd_data & cwlt_pkg::UTF8_MASK) == cwlt_pkg::UTF8_CONT;
    sts.last_idx  = (idx + cwlt_pkg::LEN_W'(1)) == len;
    sts.out_free  = !out_valid || out_ready;
  end

  // word buffer
  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[raw_eff[cwlt_pkg::ADDR_W-1:0]] <= in_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word  <= 1'b0;
      raw_len  <= '0;
      trim_len <= '0;
      len      <= '0;
      idx      <= '0;
      count    <= '0;
    end else begin
      if (cmd.clear_word) begin
        in_word  <= 1'b0;
        raw_len  <= '0;
        trim_len <= '0;
      end else if (cmd.store) begin
        in_word  <= 1'b1;
        raw_len  <= raw_next;
        trim_len <= sts.is_blank ? trim_eff : raw_next;
      end
      if (cmd.close) begin
        len <= sts.trim_gt ? cwlt_pkg::LEN_W'(cwlt_pkg::WORD_BYTES) : trim_len;
      end else if (cmd.bk_dec) begin
        len <= len - cwlt_pkg::LEN_W'(1);
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + cwlt_pkg::LEN_W'(1);
      end
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + cwlt_pkg::CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_word || cmd.ld_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_word) begin
      kind        <= cwlt_pkg::KIND_WORD;
      word_byte   <= rd_data;
      word_index  <= 4'(count);
      word_end    <= sts.last_idx;
      word_total  <= '0;
      last_of_run <= cmd.ld_last;
    end else if (cmd.ld_end) begin
      kind        <= cwlt_pkg::KIND_END;
      word_byte   <= '0;
      word_index  <= '0;
      word_end    <= 1'b0;
      word_total  <= 4'(count);
      last_of_run <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cwlt_ctrl.sv
// control state machine of the tokenizer: byte intake, utf-8 back-off, emit
// uses cwlt_pkg command and status types, drives cwlt_datapath
`default_nettype none
module cwlt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cwlt_pkg::sts_t sts,
  output cwlt_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BK_RD,
    S_BK_CK,
    S_RD,
    S_OUT,
    S_END
  } state_t;

  state_t state;
  state_t state_next;
  logic   nul;
  logic   nul_next;

  always_comb begin
    state_next = state;
    nul_next   = nul;
    cmd        = '0;
    in_ready   = state == S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_nul) begin
            cmd.clear_word = 1'b1;
            nul_next       = 1'b1;
            if (sts.in_word && !sts.full) begin
              cmd.close = 1'b1;
              if (sts.trim_gt) begin
                state_next = S_BK_RD;
              end else if (sts.trim_zero) begin
                state_next = S_END;
              end else begin
                cmd.idx_clr = 1'b1;
                state_next  = S_RD;
              end
            end else begin
              state_next = S_END;
            end
          end else if (sts.full) begin
            state_next = S_IDLE;
          end else if (!sts.in_word && (sts.is_comma || sts.is_blank)) begin
            state_next = S_IDLE;
          end else if (sts.is_comma) begin
            cmd.clear_word = 1'b1;
            cmd.close      = 1'b1;
            nul_next       = 1'b0;
            if (sts.trim_gt) begin
              state_next = S_BK_RD;
            end else if (!sts.trim_zero) begin
              cmd.idx_clr = 1'b1;
              state_next  = S_RD;
            end
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      S_BK_RD: begin
        cmd.rd_from_len = 1'b1;
        state_next      = S_BK_CK;
      end
      S_BK_CK: begin
        if (!sts.len_zero && sts.cont) begin
          cmd.bk_dec = 1'b1;
          state_next = S_BK_RD;
        end else if (sts.len_zero) begin
          state_next = nul ? S_END : S_IDLE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_word = 1'b1;
          cmd.ld_last = sts.last_idx && !nul;
          if (sts.last_idx) begin
            cmd.count_inc = 1'b1;
            state_next    = nul ? S_END : S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.ld_end    = 1'b1;
          cmd.count_clr = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nul   <= 1'b0;
    end else begin
      state <= state_next;
      nul   <= nul_next;
    end
  end

endmodule
`default_nettype wire
